@@ hdl/lfpd_pkg.sv @@
// shared types and codes for the led fade pwm driver
package lfpd_pkg;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_PWM    = 2'd0,
    FUNC_FADE   = 2'd1,
    FUNC_SUPER  = 2'd2,
    FUNC_TARGET = 2'd3
  } func_t;

endpackage

@@ hdl/lfpd_fade_bank.sv @@
// bank of channel brightness registers with fade stepping and pwm compare
module lfpd_fade_bank #(
  parameter int NUM_CH     = 8,
  parameter int FULL_STEPS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fade,
  input  logic [NUM_CH-1:0]                 goal,
  input  logic [$clog2(FULL_STEPS)-1:0]     phase,
  output logic [NUM_CH-1:0]                 bits
);

  localparam int BW = $clog2(FULL_STEPS + 1);
  localparam int PW = $clog2(FULL_STEPS);
  localparam logic [BW-1:0] FULL = BW'(FULL_STEPS);

  logic [BW-1:0] brightness      [NUM_CH];
  logic [BW-1:0] brightness_next [NUM_CH];

  // one saturating step toward the goal per channel
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      brightness_next[i] = brightness[i];
      if (goal[i]) begin
        if (brightness[i] < FULL) brightness_next[i] = brightness[i] + 1'b1;
      end else begin
        if (brightness[i] != '0) brightness_next[i] = brightness[i] - 1'b1;
      end
    end
  end

  // brightness registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) brightness[i] <= '0;
    end else if (fade) begin
      for (int i = 0; i < NUM_CH; i++) brightness[i] <= brightness_next[i];
    end
  end

  // channel is on while phase is below its brightness
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      bits[i] = ({{(BW - PW){1'b0}}, phase} < brightness[i]);
    end
  end

endmodule

@@ hdl/led_fade_pwm_driver.sv @@
// led fade pwm driver top level: item register, state update, result register
// a pwm item passes the item register, then its result is loaded and out_valid rises
// throughput: one item per cycle; only pwm items wait on a full result register
// other items update state from the item register and give no result
// reset (synchronous, active high) clears phase, brightness, goals, blink,
// traffic mark and both valid flags
module led_fade_pwm_driver #(
  parameter int NUM_LIGHTS = 15,
  parameter int NUM_LEVELS = 8,
  parameter int FULL_STEPS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            func,
  input  logic [NUM_LIGHTS-1:0] light_target,
  input  logic [NUM_LEVELS-1:0] level_target,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [NUM_LIGHTS-1:0] light_bits,
  output logic [NUM_LEVELS-1:0] level_bits
);
  import lfpd_pkg::*;

  localparam int PW = $clog2(FULL_STEPS);
  localparam logic [PW-1:0] LAST_PHASE = PW'(FULL_STEPS - 1);

  // item register
  logic                  item_valid;
  func_t                 item_func;
  logic [NUM_LIGHTS-1:0] item_light;
  logic [NUM_LEVELS-1:0] item_level;
  logic                  item_go;

  // block state
  logic [PW-1:0]         pwm_phase;
  logic [PW-1:0]         pwm_phase_next;
  logic [NUM_LIGHTS-1:0] light_goal;
  logic [NUM_LEVELS-1:0] level_goal;
  logic                  blink_phase;
  logic                  traffic_seen;
  logic                  fade;
  logic [NUM_LIGHTS-1:0] light_cmp;
  logic [NUM_LEVELS-1:0] level_cmp;

  // a pwm item proceeds only when the result register can take it
  assign item_go  = item_valid &&
                    ((item_func != FUNC_PWM) || !out_valid || out_ready);
  assign in_ready = !item_valid || item_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_func  <= func_t'(func);
      item_light <= light_target;
      item_level <= level_target;
    end
  end

  // phase wraps after the last step
  assign pwm_phase_next = (pwm_phase == LAST_PHASE) ? '0 : pwm_phase + 1'b1;
  assign fade = item_go && (item_func == FUNC_FADE);

  // phase, goals, blink and traffic mark
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_phase    <= '0;
      light_goal   <= '0;
      level_goal   <= '0;
      blink_phase  <= 1'b0;
      traffic_seen <= 1'b0;
    end else if (item_go) begin
      case (item_func)
        FUNC_PWM: begin
          pwm_phase <= pwm_phase_next;
        end
        FUNC_SUPER: begin
          blink_phase  <= ~blink_phase;
          if (!traffic_seen) level_goal <= {NUM_LEVELS{~blink_phase}};
          traffic_seen <= 1'b0;
        end
        FUNC_TARGET: begin
          light_goal   <= item_light;
          level_goal   <= item_level;
          traffic_seen <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  lfpd_fade_bank #(
    .NUM_CH     (NUM_LIGHTS),
    .FULL_STEPS (FULL_STEPS)
  ) u_light_bank (
    .clk   (clk),
    .rst   (rst),
    .fade  (fade),
    .goal  (light_goal),
    .phase (pwm_phase_next),
    .bits  (light_cmp)
  );

  lfpd_fade_bank #(
    .NUM_CH     (NUM_LEVELS),
    .FULL_STEPS (FULL_STEPS)
  ) u_level_bank (
    .clk   (clk),
    .rst   (rst),
    .fade  (fade),
    .goal  (level_goal),
    .phase (pwm_phase_next),
    .bits  (level_cmp)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_go && (item_func == FUNC_PWM)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_go && (item_func == FUNC_PWM)) begin
      light_bits <= light_cmp;
      level_bits <= level_cmp;
    end
  end

endmodule

@@ hdl/lfpd_checker.sv @@
// port-level checker for the led fade pwm driver and its bind
module lfpd_checker #(
  parameter int NUM_LIGHTS = 15,
  parameter int NUM_LEVELS = 8
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [1:0]            func,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [NUM_LIGHTS-1:0] light_bits,
  input logic [NUM_LEVELS-1:0] level_bits
);
  import lfpd_pkg::*;

  logic pwm_accept;
  assign pwm_accept = in_valid && in_ready && (func == FUNC_PWM);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(light_bits) && $stable(level_bits))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a fresh result comes from a pwm item accepted through the item register
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pwm_accept, 2))
    else $error("result without a pwm item");

  // the item register always drains when the result side is free
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !in_ready |=> in_ready)
    else $error("input stalled with free result register");

endmodule

bind led_fade_pwm_driver lfpd_checker #(
  .NUM_LIGHTS (NUM_LIGHTS),
  .NUM_LEVELS (NUM_LEVELS)
) u_lfpd_checker (.*);

@@ bench/led_fade_pwm_driver_tb.sv @@
// self-checking testbench for the led fade pwm driver with a brightness predictor
module led_fade_pwm_driver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfpd_pkg::*;

  localparam int NUM_LIGHTS  = 15;
  localparam int NUM_LEVELS  = 8;
  localparam int FULL_STEPS  = 8;
  localparam int RAND_ITEMS  = 950;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [NUM_LIGHTS-1:0] light;
    logic [NUM_LEVELS-1:0] level;
  } pwm_frame_t;

  // brightness predictor plus queue of expected pwm frames
  class led_fade_scoreboard;
    logic [2:0]            phase;
    logic [3:0]            light_lvl [NUM_LIGHTS];
    logic [3:0]            level_lvl [NUM_LEVELS];
    logic [NUM_LIGHTS-1:0] light_goal;
    logic [NUM_LEVELS-1:0] level_goal;
    logic                  blink;
    logic                  traffic;
    pwm_frame_t            expected_frames [$];
    int                    errors;

    function new();
      phase      = '0;
      light_goal = '0;
      level_goal = '0;
      blink      = 1'b0;
      traffic    = 1'b0;
      errors     = 0;
      foreach (light_lvl[i]) light_lvl[i] = '0;
      foreach (level_lvl[i]) level_lvl[i] = '0;
    endfunction

    // update state for an accepted item, queue a frame on pwm ticks
    function void note_item(func_t f, logic [NUM_LIGHTS-1:0] lt, logic [NUM_LEVELS-1:0] lv);
      pwm_frame_t fr;
      int         nxt;
      case (f)
        FUNC_PWM: begin
          nxt = int'(phase) + 1;
          if (nxt >= FULL_STEPS) nxt = 0;
          phase = nxt[2:0];
          for (int i = 0; i < NUM_LIGHTS; i++) fr.light[i] = ({1'b0, phase} < light_lvl[i]);
          for (int i = 0; i < NUM_LEVELS; i++) fr.level[i] = ({1'b0, phase} < level_lvl[i]);
          expected_frames.push_back(fr);
        end
        FUNC_FADE: begin
          for (int i = 0; i < NUM_LIGHTS; i++) begin
            if (light_goal[i]) begin
              if (light_lvl[i] < FULL_STEPS) light_lvl[i] = light_lvl[i] + 4'd1;
            end else if (light_lvl[i] > 0) begin
              light_lvl[i] = light_lvl[i] - 4'd1;
            end
          end
          for (int i = 0; i < NUM_LEVELS; i++) begin
            if (level_goal[i]) begin
              if (level_lvl[i] < FULL_STEPS) level_lvl[i] = level_lvl[i] + 4'd1;
            end else if (level_lvl[i] > 0) begin
              level_lvl[i] = level_lvl[i] - 4'd1;
            end
          end
        end
        FUNC_SUPER: begin
          blink = ~blink;
          // no traffic since last supervision: level goals follow blink
          if (!traffic) level_goal = blink ? '1 : '0;
          traffic = 1'b0;
        end
        default: begin
          light_goal = lt;
          level_goal = lv;
          traffic    = 1'b1;
        end
      endcase
    endfunction

    // compare one accepted result against the oldest expected frame
    function void check_frame(logic [NUM_LIGHTS-1:0] lb, logic [NUM_LEVELS-1:0] vb);
      pwm_frame_t fr;
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected result light_bits=%h level_bits=%h", $time, lb, vb);
        errors++;
      end else begin
        fr = expected_frames.pop_front();
        if (lb !== fr.light) begin
          $display("%0t: light_bits mismatch expected=%h actual=%h", $time, fr.light, lb);
          errors++;
        end
        if (vb !== fr.level) begin
          $display("%0t: level_bits mismatch expected=%h actual=%h", $time, fr.level, vb);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            func;
  logic [NUM_LIGHTS-1:0] light_target;
  logic [NUM_LEVELS-1:0] level_target;
  logic                  out_valid;
  logic                  out_ready;
  logic [NUM_LIGHTS-1:0] light_bits;
  logic [NUM_LEVELS-1:0] level_bits;

  led_fade_scoreboard frames_sb = new();
  bit                 steady;
  int                 quiet_cycles = 0;

  led_fade_pwm_driver #(
    .NUM_LIGHTS(NUM_LIGHTS),
    .NUM_LEVELS(NUM_LEVELS),
    .FULL_STEPS(FULL_STEPS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .light_target(light_target),
    .level_target(level_target),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .light_bits  (light_bits),
    .level_bits  (level_bits)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int idle_gap();
    return steady ? 0 : $urandom_range(0, 8);
  endfunction

  // present one item after a random gap and hold it until accepted
  task automatic push_item(func_t f, logic [NUM_LIGHTS-1:0] lt, logic [NUM_LEVELS-1:0] lv);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    light_target <= lt;
    level_target <= lv;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // short directed run: saturation, all phases, supervision forcing
  task automatic run_directed();
    // targets ignored on a tick, first phase after reset is 1, all dark
    push_item(FUNC_PWM, '1, '1);
    push_item(FUNC_FADE, NUM_LIGHTS'($urandom), NUM_LEVELS'($urandom));
    push_item(FUNC_TARGET, '1, '1);
    // one extra fade checks saturation at full brightness
    repeat (FULL_STEPS + 1) push_item(FUNC_FADE, '0, '0);
    // full brightness is on in every phase
    repeat (FULL_STEPS) push_item(FUNC_PWM, '0, '0);
    push_item(FUNC_TARGET, '0, '0);
    // traffic seen: no forcing; then quiet periods force off, then on
    push_item(FUNC_SUPER, '1, '1);
    push_item(FUNC_SUPER, '0, '0);
    push_item(FUNC_SUPER, '1, '0);
    push_item(FUNC_FADE, '0, '1);
    push_item(FUNC_PWM, '1, '0);
  endtask

  // random mix weighted toward ticks so brightness sweeps all levels
  task automatic run_random();
    int                    pick;
    func_t                 f;
    logic [NUM_LIGHTS-1:0] lt;
    logic [NUM_LEVELS-1:0] lv;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 35)      f = FUNC_PWM;
      else if (pick < 65) f = FUNC_FADE;
      else if (pick < 77) f = FUNC_SUPER;
      else                f = FUNC_TARGET;
      lt = NUM_LIGHTS'($urandom);
      lv = NUM_LEVELS'($urandom);
      case ($urandom_range(0, 7))
        0: begin lt = '1; lv = '1; end
        1: begin lt = '0; lv = '0; end
        default: ;
      endcase
      push_item(f, lt, lv);
    end
    steady = 1'b0;
  endtask

  // monitor: check results, then note accepted items
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) frames_sb.check_frame(light_bits, level_bits);
      if (in_valid && in_ready) frames_sb.note_item(func_t'(func), light_target, level_target);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stall before taking each result
  initial begin
    int w;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      w = idle_gap();
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // reset, stimulus, drain and verdict
  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    func         = FUNC_PWM;
    light_target = '0;
    level_target = '0;
    steady       = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    in_valid <= 1'b0;
    while (frames_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (frames_sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
